@@ sv/bandpass_filter_frame_energy_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef BANDPASS_FILTER_FRAME_ENERGY_TOP_ASSERT_SVH
`define BANDPASS_FILTER_FRAME_ENERGY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BPFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BPFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bpfe_pkg.sv @@
`default_nettype none

package bpfe_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned FILT_W   = 12;
  localparam int unsigned MS_W     = 19;
  localparam int unsigned SQ_W     = 19;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COEF_W   = 18;

  // Result queue behind the output stage.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // Q2.16 filter coefficients.
  localparam logic signed [COEF_W-1:0] COEF_B = 18'sd27178;
  localparam logic signed [COEF_W-1:0] COEF_A [4] = '{
    -18'sd13544, -18'sd1832, -18'sd11872, 18'sd92339
  };

  localparam logic signed [SAMPLE_W:0] MID_SCALE = 11'sd512;

  typedef struct packed {
    logic signed [WORD_W-1:0] v;
    logic signed [WORD_W-1:0] w0;
    logic signed [WORD_W-1:0] w2;
  } iir_tap_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic                     frame_end;
    logic [MS_W-1:0]          mean_square;
  } result_t;

endpackage

`default_nettype wire

@@ sv/bpfe_iir.sv @@
`default_nettype none

module bpfe_iir (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic [bpfe_pkg::SAMPLE_W-1:0] sample_i,
  output bpfe_pkg::iir_tap_t            tap_o
);

  localparam int unsigned X_W     = bpfe_pkg::SAMPLE_W + 11;
  localparam int unsigned ACC_W   = 52;
  localparam int unsigned RND_SH  = 16;
  localparam int unsigned VR_W    = ACC_W - RND_SH;
  localparam int unsigned WORD_W  = bpfe_pkg::WORD_W;
  localparam int unsigned COEF_W  = bpfe_pkg::COEF_W;

  logic signed [WORD_W-1:0]        hist_q [4];
  logic signed [X_W-1:0]           x;
  logic signed [COEF_W+X_W-1:0]    prod_b;
  logic signed [COEF_W+WORD_W-1:0] prod_a [4];
  logic signed [ACC_W-1:0]         acc;
  logic signed [VR_W-1:0]          vr;
  logic signed [WORD_W-1:0]        v;

  // Raw sample as Q11.10, no mid-scale removal.
  assign x = $signed({1'b0, sample_i, 10'b0});

  always_comb begin
    prod_b = bpfe_pkg::COEF_B * x;
    for (int i = 0; i < 4; i++) begin
      prod_a[i] = bpfe_pkg::COEF_A[i] * hist_q[i];
    end
    acc = ACC_W'(prod_b) + ACC_W'(prod_a[0]) + ACC_W'(prod_a[1])
        + ACC_W'(prod_a[2]) + ACC_W'(prod_a[3]) + ACC_W'(32'sd32768);
    vr  = acc[ACC_W-1:RND_SH];
    // Saturate to the 32-bit word range.
    if ((&vr[VR_W-1:WORD_W-1]) || !(|vr[VR_W-1:WORD_W-1])) begin
      v = vr[WORD_W-1:0];
    end else if (vr[VR_W-1]) begin
      v = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      v = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= '0;
      end
    end else if (advance_i) begin
      hist_q[0] <= hist_q[1];
      hist_q[1] <= hist_q[2];
      hist_q[2] <= hist_q[3];
      hist_q[3] <= v;
    end
  end

  assign tap_o.v  = v;
  assign tap_o.w0 = hist_q[0];
  assign tap_o.w2 = hist_q[2];

endmodule

`default_nettype wire

@@ sv/bpfe_fifo.sv @@
`default_nettype none

module bpfe_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  bpfe_pkg::result_t               push_data_i,
  input  logic                            pop_i,
  output bpfe_pkg::result_t               pop_data_o,
  output logic [bpfe_pkg::FIFO_CNT_W-1:0] count_o
);

  localparam int unsigned PTR_W = bpfe_pkg::FIFO_PTR_W;
  localparam int unsigned CNT_W = bpfe_pkg::FIFO_CNT_W;

  bpfe_pkg::result_t mem_q [bpfe_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;

  assign count_d = count_q + CNT_W'(push_i) - CNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign count_o    = count_q;

endmodule

`default_nettype wire

@@ sv/bandpass_filter_frame_energy_top.sv @@
`default_nettype none
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_stall_o   sample_i
// out      out  out_valid_o / out_stall_i filtered_o, frame_end_o, mean_square_o
//
// One request per cycle while in_stall_o is low; the filter recursion closes
// combinationally through the five coefficient multipliers. A result is
// registered in the s1 stage, then written to the result queue and offered.
// Reset clears the filter history, frame sum and frame position at once.
// A four-entry result queue holds results under out_stall_i; in_stall_o rises
// only when the queue plus the request in flight fill it.

module bandpass_filter_frame_energy_top #(
  parameter int unsigned FRAME_SIZE = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bpfe_pkg::SAMPLE_W-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bpfe_pkg::FILT_W-1:0]   filtered_o,
  output logic                                 frame_end_o,
  output logic [bpfe_pkg::MS_W-1:0]            mean_square_o
);

  localparam int unsigned SAMPLE_W  = bpfe_pkg::SAMPLE_W;
  localparam int unsigned WORD_W    = bpfe_pkg::WORD_W;
  localparam int unsigned FILT_W    = bpfe_pkg::FILT_W;
  localparam int unsigned MS_W      = bpfe_pkg::MS_W;
  localparam int unsigned CNT_W     = bpfe_pkg::FIFO_CNT_W;
  localparam int unsigned POS_W     = $clog2(FRAME_SIZE);
  localparam int unsigned SUM_W     = POS_W + bpfe_pkg::SQ_W;
  localparam int unsigned Y_W       = WORD_W + 2;
  localparam int unsigned YI_W      = Y_W - 10;
  // Exact floor division by FRAME_SIZE through a rounded-up reciprocal.
  localparam int unsigned DIV_SHIFT = SUM_W + POS_W;
  localparam logic [63:0] DIV_MUL_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(FRAME_SIZE) - 64'd1) / 64'(FRAME_SIZE);
  localparam logic [SUM_W:0] DIV_MUL = DIV_MUL_FULL[SUM_W:0];

  logic                      in_accept;
  bpfe_pkg::iir_tap_t        tap;
  logic signed [SAMPLE_W:0]  dev;
  logic signed [2*SAMPLE_W+1:0] sq_full;
  logic [bpfe_pkg::SQ_W-1:0] sq;
  logic [SUM_W-1:0]          total;
  logic                      frame_last;

  logic [POS_W-1:0]          pos_q;
  logic [SUM_W-1:0]          energy_q;
  logic                      s1_valid_q;
  bpfe_pkg::iir_tap_t        s1_tap_q;
  logic                      s1_last_q;
  logic [SUM_W-1:0]          s1_total_q;

  logic signed [Y_W-1:0]     y;
  logic signed [YI_W-1:0]    yi;
  logic signed [FILT_W-1:0]  filt;
  logic [2*SUM_W:0]          div_prod;
  bpfe_pkg::result_t         push_data;
  bpfe_pkg::result_t         pop_data;
  logic [CNT_W-1:0]          fifo_count;
  logic                      pop;

  // Stall while the queue has no room for the request in flight plus one more.
  assign in_stall_o = (fifo_count + CNT_W'(s1_valid_q)) >= CNT_W'(bpfe_pkg::FIFO_DEPTH);
  assign in_accept  = in_valid_i && !in_stall_o;

  bpfe_iir u_iir (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_accept),
    .sample_i  (sample_i),
    .tap_o     (tap)
  );

  assign dev        = $signed({1'b0, sample_i}) - bpfe_pkg::MID_SCALE;
  assign sq_full    = dev * dev;
  assign sq         = sq_full[bpfe_pkg::SQ_W-1:0];
  assign total      = energy_q + SUM_W'(sq);
  assign frame_last = pos_q >= POS_W'(FRAME_SIZE - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      energy_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      if (in_accept) begin
        // Clear the sum and restart the frame on its last sample.
        pos_q    <= frame_last ? '0 : pos_q + 1'b1;
        energy_q <= frame_last ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_tap_q   <= tap;
      s1_last_q  <= frame_last;
      s1_total_q <= total;
    end
  end

  always_comb begin
    y = Y_W'(s1_tap_q.w0) + Y_W'(s1_tap_q.v) - (Y_W'(s1_tap_q.w2) <<< 1);
    yi = y[Y_W-1:10];
    if ((&yi[YI_W-1:FILT_W-1]) || !(|yi[YI_W-1:FILT_W-1])) begin
      filt = yi[FILT_W-1:0];
    end else if (yi[YI_W-1]) begin
      filt = {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      filt = {1'b0, {(FILT_W-1){1'b1}}};
    end
  end

  assign div_prod = s1_total_q * DIV_MUL;

  assign push_data.filtered    = filt;
  assign push_data.frame_end   = s1_last_q;
  assign push_data.mean_square = s1_last_q ? div_prod[DIV_SHIFT +: MS_W] : '0;

  assign pop = out_valid_o && !out_stall_i;

  bpfe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .count_o     (fifo_count)
  );

  assign out_valid_o   = fifo_count != '0;
  assign filtered_o    = pop_data.filtered;
  assign frame_end_o   = pop_data.frame_end;
  assign mean_square_o = pop_data.mean_square;

endmodule

`default_nettype wire

@@ sv/bandpass_filter_frame_energy_top_chk.sv @@
`default_nettype none
`include "bandpass_filter_frame_energy_top_assert.svh"

module bandpass_filter_frame_energy_top_chk #(
  parameter int unsigned FRAME_SIZE = 256
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [bpfe_pkg::SAMPLE_W-1:0]        sample_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [bpfe_pkg::FILT_W-1:0]   filtered_o,
  input logic                                 frame_end_o,
  input logic [bpfe_pkg::MS_W-1:0]            mean_square_o
);

  localparam int unsigned CNT_W = $clog2(FRAME_SIZE);

  logic             out_acc;
  logic [CNT_W-1:0] out_cnt_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // Count results since the last frame end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (out_acc) begin
      out_cnt_q <= frame_end_o ? '0 : out_cnt_q + 1'b1;
    end
  end

  `BPFE_ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o, "out valid dropped under stall")
  `BPFE_ASSERT_NEXT(a_out_data_hold, out_valid_o && out_stall_i, $stable(filtered_o) && $stable(frame_end_o) && $stable(mean_square_o), "out payload changed under stall")
  `BPFE_ASSERT_NOW(a_ms_zero, out_valid_o && !frame_end_o, mean_square_o == '0, "mean square set outside frame end")
  `BPFE_ASSERT_NOW(a_frame_len, out_acc && frame_end_o, out_cnt_q == CNT_W'(FRAME_SIZE - 1), "frame end at wrong result count")
  `BPFE_ASSERT_NOW(a_frame_early, out_acc && !frame_end_o, out_cnt_q < CNT_W'(FRAME_SIZE - 1), "frame end missed")

endmodule

bind bandpass_filter_frame_energy_top bandpass_filter_frame_energy_top_chk #(
  .FRAME_SIZE(FRAME_SIZE)
) u_chk (.*);

`default_nettype wire
